@@ src/deadtime_corrected_window_averager_defines.svh @@
// Assertion macros for the dead-time corrected window averager.
// Included by the top level; depends on nothing else.
`ifndef DEADTIME_CORRECTED_WINDOW_AVERAGER_DEFINES_SVH
`define DEADTIME_CORRECTED_WINDOW_AVERAGER_DEFINES_SVH
`ifndef ASSERT_OFF
`define DCWA_ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define DCWA_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define DCWA_ASSERT_SAME(label, clk, rstn, a, b)
`define DCWA_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ src/dcwa_pkg.sv @@
// Shared constants and widths of the dead-time corrected window averager.
// Used by the top level; depends on nothing.
package dcwa_pkg;
    localparam int WINDOW_DEPTH = 32;
    localparam int SENSOR_COUNT = 12;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int SENS_W       = 4;
    localparam int RATE_W       = 40;
    localparam int SUM_W        = RATE_W + PTR_W;
    localparam int S_TDATA_W    = 136;
    localparam int S_TUSER_W    = 4;
    localparam int M_TDATA_W    = 88;

    // Opcodes of an input beat.
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_GAIN   = 2'd2;

    // Register indexes of the configuration port.
    localparam logic CFG_DT_LOW  = 1'b0;
    localparam logic CFG_DT_HIGH = 1'b1;

    localparam logic [1:0]  FRAMES_PER_SET = 2'd3;
    localparam logic [5:0]  WIN_SLOW       = 6'd30;
    localparam logic [5:0]  WIN_MID        = 6'd10;
    localparam logic [5:0]  WIN_FAST       = 6'd2;
    localparam logic [15:0] RATE_SLOW_LIM  = 16'd3;
    localparam logic [15:0] RATE_MID_LIM   = 16'd12;
    localparam logic [SENS_W-1:0] LAST_SENSOR = SENS_W'(SENSOR_COUNT - 1);
endpackage

@@ src/deadtime_corrected_window_averager.sv @@
// Dead-time corrected window averager: correction, history memories, averaging.
// Depends on dcwa_pkg and deadtime_corrected_window_averager_defines.svh.
// After the third count beat, the 12 counts are corrected in turn (a saturated count
// skips the division), then the dose and sensor-zero means give the first result;
// each further result is summed and divided after the previous output beat is taken.
// One beat at a time, ready low while busy; sync reset spares datapath regs and RAMs.
`include "deadtime_corrected_window_averager_defines.svh"
module deadtime_corrected_window_averager (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: counter_rate, dose_rate, count_a, count_b, count_c, count_d,
    // gain_index, gain_value, zero fill.
    input  logic [dcwa_pkg::S_TDATA_W-1:0] s_tdata,
    // From bit 0: op, range_select.
    input  logic [dcwa_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: sensor_index, corrected_average, average_dose, window_length,
    // window_full, zero fill.
    output logic [dcwa_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [31:0]                    cfg_data
);
    import dcwa_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    localparam int RMEM_DEPTH = WINDOW_DEPTH * (2 ** SENS_W);
    localparam logic [5:0] DEPTH6 = 6'(WINDOW_DEPTH);
    localparam logic [5:0] CORR_STEPS = 6'd40;
    localparam logic [5:0] AVG_STEPS = 6'(SUM_W);

    logic [2:0]          state_reg, state_next;
    logic [31:0]         dt_lo_reg, dt_hi_reg;
    logic [17:0]         gain_reg [2][SENSOR_COUNT];
    logic [15:0]         stage_reg [3][4];
    logic [1:0]          frame_reg, frame_next;
    logic                range_reg, range_next;
    logic [31:0]         dose_reg, dose_next;
    logic [15:0]         rate_reg, rate_next;
    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [5:0]          fill_reg, fill_next;
    logic                full_reg, full_next;
    logic [5:0]          n_reg, n_next;
    logic [SENS_W-1:0]   sens_reg, sens_next;
    logic [47:0]         prod_reg, prod_next;
    logic [33:0]         num_reg, num_next;
    logic [32:0]         rem_reg, rem_next;
    logic [32:0]         den_reg, den_next;
    logic [SUM_W-1:0]    dvd_reg, dvd_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                avg_mode_reg, avg_mode_next;
    logic                dose_mode_reg, dose_mode_next;
    logic [PTR_W-1:0]    idx_reg, idx_next;
    logic [5:0]          issue_reg, issue_next;
    logic                rdv_reg, rdv_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [31:0]         avg_dose_reg, avg_dose_next;
    logic [RATE_W-1:0]   out_avg_reg, out_avg_next;

    logic [RATE_W-1:0]   rate_mem [RMEM_DEPTH];
    logic [31:0]         dose_mem [WINDOW_DEPTH];
    logic [RATE_W-1:0]   rate_rd_reg;
    logic [31:0]         dose_rd_reg;

    logic                s_beat, m_beat;
    logic [1:0]          in_op, in_rs;
    logic [3:0]          in_gi;
    logic [17:0]         in_gv;
    logic [15:0]         in_cnt [4];
    logic [33:0]         rem_sh;
    logic                div_ge;
    logic [32:0]         den_full;
    logic                sat;
    logic [15:0]         cur_count;
    logic [31:0]         cur_dt;

    assign in_op     = s_tuser[1:0];
    assign in_rs     = s_tuser[3:2];
    assign in_cnt[0] = s_tdata[63:48];
    assign in_cnt[1] = s_tdata[79:64];
    assign in_cnt[2] = s_tdata[95:80];
    assign in_cnt[3] = s_tdata[111:96];
    assign in_gi     = s_tdata[115:112];
    assign in_gv     = s_tdata[133:116];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_beat    = m_tvalid && m_tready;
    assign m_tlast   = (sens_reg == LAST_SENSOR);
    assign m_tdata   = {5'd0, full_reg, n_reg, avg_dose_reg, out_avg_reg, sens_reg};
    assign cfg_ready = 1'b1;

    // One restoring division step.
    assign rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge = (rem_sh >= {1'b0, den_reg});

    // Correction operands and the saturation test.
    assign cur_count = stage_reg[sens_reg[3:2]][sens_reg[1:0]];
    assign cur_dt    = range_reg ? dt_hi_reg : dt_lo_reg;
    assign den_full  = {1'b1, 32'd0} - {1'b0, prod_reg[31:0]};
    assign sat       = (prod_reg[47:32] != 16'd0) ||
                       ({7'd0, num_reg} >= {den_full, 8'd0});

    // History memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) begin
            rate_mem[{wp_reg, sens_reg}] <= quo_reg[RATE_W-1:0];
            if (sens_reg == LAST_SENSOR) begin
                dose_mem[wp_reg] <= dose_reg;
            end
        end
        rate_rd_reg <= rate_mem[{idx_reg, sens_reg}];
        dose_rd_reg <= dose_mem[idx_reg];
    end

    // Gain table and count staging.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 2; r++) begin
                for (int j = 0; j < SENSOR_COUNT; j++) begin
                    gain_reg[r][j] <= '0;
                end
            end
            for (int f = 0; f < 3; f++) begin
                for (int j = 0; j < 4; j++) begin
                    stage_reg[f][j] <= '0;
                end
            end
        end else if (s_beat) begin
            if (in_op == OP_GAIN && in_gi < 4'(SENSOR_COUNT) && in_rs < 2'd2) begin
                gain_reg[in_rs[0]][in_gi] <= in_gv;
            end
            if (in_op == OP_COUNT && frame_reg != FRAMES_PER_SET) begin
                for (int j = 0; j < 4; j++) begin
                    stage_reg[frame_reg][j] <= in_cnt[j];
                end
            end
        end
    end

    // Dead-time registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_lo_reg <= '0;
            dt_hi_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DT_LOW:  dt_lo_reg <= cfg_data;
                CFG_DT_HIGH: dt_hi_reg <= cfg_data;
                default:     dt_lo_reg <= dt_lo_reg;
            endcase
        end
    end

    // Sequencer: correction, history write, window sums and divisions.
    always_comb begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        range_next     = range_reg;
        dose_next      = dose_reg;
        rate_next      = rate_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        full_next      = full_reg;
        n_next         = n_reg;
        sens_next      = sens_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        avg_mode_next  = avg_mode_reg;
        dose_mode_next = dose_mode_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        rdv_next       = 1'b0;
        acc_next       = acc_reg;
        avg_dose_next  = avg_dose_reg;
        out_avg_next   = out_avg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    case (in_op)
                        OP_HEADER: begin
                            if (in_rs < 2'd2) begin
                                range_next = in_rs[0];
                            end
                            rate_next  = s_tdata[15:0];
                            dose_next  = s_tdata[47:16];
                            frame_next = 2'd0;
                        end
                        OP_COUNT: begin
                            if (frame_reg != FRAMES_PER_SET) begin
                                frame_next = frame_reg + 2'd1;
                                if (frame_next == FRAMES_PER_SET) begin
                                    // Pick the window length of this set.
                                    if (fill_reg < DEPTH6) begin
                                        fill_next = fill_reg + 6'd1;
                                        n_next    = fill_next;
                                    end else begin
                                        full_next = 1'b1;
                                        if (rate_reg < RATE_SLOW_LIM) begin
                                            n_next = WIN_SLOW;
                                        end else if (rate_reg < RATE_MID_LIM) begin
                                            n_next = WIN_MID;
                                        end else begin
                                            n_next = WIN_FAST;
                                        end
                                        if (n_next > DEPTH6) begin
                                            n_next = DEPTH6;
                                        end
                                    end
                                    sens_next  = '0;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                prod_next  = {32'd0, cur_count} * {16'd0, cur_dt};
                num_next   = {18'd0, cur_count} * {16'd0, gain_reg[range_reg][sens_reg]};
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (sat) begin
                    quo_next   = {{(SUM_W-RATE_W){1'b0}}, {RATE_W{1'b1}}};
                    state_next = ST_WR;
                end else begin
                    rem_next      = {7'd0, num_reg[33:8]};
                    den_next      = den_full;
                    dvd_next      = {num_reg[7:0], {(SUM_W-8){1'b0}}};
                    quo_next      = '0;
                    cnt_next      = CORR_STEPS;
                    avg_mode_next = 1'b0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? 33'(rem_sh - {1'b0, den_reg}) : rem_sh[32:0];
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                quo_next = {quo_reg[SUM_W-2:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    if (!avg_mode_reg) begin
                        state_next = ST_WR;
                    end else if (dose_mode_reg) begin
                        // Dose mean done; start on sensor zero.
                        avg_dose_next  = quo_next[31:0];
                        dose_mode_next = 1'b0;
                        sens_next      = '0;
                        idx_next       = wp_reg - PTR_W'(1);
                        issue_next     = '0;
                        acc_next       = '0;
                        state_next     = ST_SUM;
                    end else begin
                        out_avg_next = quo_next[RATE_W-1:0];
                        state_next   = ST_OUT;
                    end
                end
            end
            ST_WR: begin
                if (sens_reg == LAST_SENSOR) begin
                    wp_next        = wp_reg + PTR_W'(1);
                    idx_next       = wp_reg;
                    issue_next     = '0;
                    acc_next       = '0;
                    dose_mode_next = 1'b1;
                    state_next     = ST_SUM;
                end else begin
                    sens_next  = sens_reg + SENS_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_SUM: begin
                // Walk back from the newest entry, one read a cycle.
                if (issue_reg != n_reg) begin
                    idx_next   = idx_reg - PTR_W'(1);
                    issue_next = issue_reg + 6'd1;
                    rdv_next   = 1'b1;
                end
                if (rdv_reg) begin
                    acc_next = acc_reg + (dose_mode_reg ?
                        SUM_W'(dose_rd_reg) : SUM_W'(rate_rd_reg));
                end
                if (issue_reg == n_reg && !rdv_reg) begin
                    rem_next      = '0;
                    den_next      = {27'd0, n_reg};
                    dvd_next      = acc_reg;
                    quo_next      = '0;
                    cnt_next      = AVG_STEPS;
                    avg_mode_next = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_OUT: begin
                if (m_beat) begin
                    if (sens_reg == LAST_SENSOR) begin
                        state_next = ST_IDLE;
                    end else begin
                        sens_next  = sens_reg + SENS_W'(1);
                        idx_next   = wp_reg - PTR_W'(1);
                        issue_next = '0;
                        acc_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_reg     <= '0;
            range_reg     <= 1'b0;
            dose_reg      <= '0;
            rate_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            rdv_reg       <= 1'b0;
            dose_mode_reg <= 1'b0;
            avg_mode_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            range_reg     <= range_next;
            dose_reg      <= dose_next;
            rate_reg      <= rate_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            full_reg      <= full_next;
            rdv_reg       <= rdv_next;
            dose_mode_reg <= dose_mode_next;
            avg_mode_reg  <= avg_mode_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        sens_reg     <= sens_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        issue_reg    <= issue_next;
        acc_reg      <= acc_next;
        avg_dose_reg <= avg_dose_next;
        out_avg_reg  <= out_avg_next;
    end

    // Checks.
    `DCWA_ASSERT_SAME(a_no_overlap, aclk, aresetn, s_tready, !m_tvalid)
    `DCWA_ASSERT_SAME(a_last_index, aclk, aresetn, m_tvalid && m_tlast, m_tdata[3:0] == LAST_SENSOR)
    `DCWA_ASSERT_NEXT(a_idle_after_set, aclk, aresetn, m_beat && m_tlast, s_tready)
    `DCWA_ASSERT_SAME(a_fill_bound, aclk, aresetn, m_tvalid, fill_reg <= DEPTH6 && n_reg != 6'd0)
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the dead-time corrected window averager.
// Depends on dcwa_pkg and the deadtime_corrected_window_averager RTL.
module tb_top;
    import dcwa_pkg::*;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         IDLE_LIMIT  = 20000;
    localparam int         DRAIN_WAIT  = 2000;
    localparam longint unsigned RATE_MAX = (64'd1 << 40) - 64'd1;
    localparam longint unsigned ONE_Q32  = 64'd1 << 32;

    typedef struct {
        logic [1:0]  op;
        logic [1:0]  rsel;
        logic [15:0] rate;
        logic [31:0] dose;
        logic [15:0] cnt [4];
        logic [3:0]  gidx;
        logic [17:0] gval;
    } frame_t;

    typedef struct {
        logic [3:0]  sensor;
        logic [39:0] avg_rate;
        logic [31:0] avg_dose;
        logic [5:0]  win_len;
        logic        win_full;
        logic        last;
    } average_t;

    // Scoreboard: mirrors the block's state and holds the averages still due.
    class window_average_board_t;
        logic [31:0] dt_low, dt_high;
        logic [17:0] gains [2*SENSOR_COUNT];
        logic [15:0] staging [SENSOR_COUNT];
        int          frames;
        logic        rng;
        logic [31:0] dose;
        logic [15:0] rate;
        logic [39:0] rate_hist [WINDOW_DEPTH][SENSOR_COUNT];
        logic [31:0] dose_hist [WINDOW_DEPTH];
        int          wp, fill;
        logic        full;
        average_t    due_q [$];
        int          errors;

        function new();
            dt_low = '0; dt_high = '0;
            foreach (gains[i]) gains[i] = '0;
            foreach (staging[i]) staging[i] = '0;
            frames = 0; rng = 1'b0; dose = '0; rate = '0;
            wp = 0; fill = 0; full = 1'b0; errors = 0;
        endfunction

        function void set_dead_time(logic idx, logic [31:0] val);
            if (idx == CFG_DT_LOW) dt_low = val;
            else dt_high = val;
        endfunction

        // Corrected rate: count*gain / (1 - count*dead_time), saturating.
        function logic [39:0] correct(longint unsigned cnt, longint unsigned g,
                                      longint unsigned dt);
            longint unsigned prod, den, num, ip, rem, frac;
            prod = cnt * dt;
            if (prod >= ONE_Q32) return RATE_MAX[39:0];
            den = ONE_Q32 - prod;
            num = cnt * g;
            ip = num / den;
            if (ip >= 256) return RATE_MAX[39:0];
            rem = num % den;
            frac = (rem << 32) / den;
            return 40'((ip << 32) + frac);
        endfunction

        function void complete_set();
            longint unsigned sums [SENSOR_COUNT];
            longint unsigned dsum, dt;
            int n, idx;
            average_t r;
            dt = rng ? dt_high : dt_low;
            if (fill < WINDOW_DEPTH) begin
                fill++;
                n = fill;
            end else begin
                full = 1'b1;
                n = (rate < RATE_SLOW_LIM) ? WIN_SLOW :
                    (rate < RATE_MID_LIM) ? WIN_MID : WIN_FAST;
            end
            for (int j = 0; j < SENSOR_COUNT; j++)
                rate_hist[wp][j] = correct(staging[j], gains[rng*SENSOR_COUNT + j], dt);
            dose_hist[wp] = dose;
            wp = (wp + 1) % WINDOW_DEPTH;
            foreach (sums[j]) sums[j] = 0;
            dsum = 0;
            idx = wp;
            for (int k = 0; k < n; k++) begin
                idx = (idx + WINDOW_DEPTH - 1) % WINDOW_DEPTH;
                dsum += dose_hist[idx];
                for (int j = 0; j < SENSOR_COUNT; j++) sums[j] += rate_hist[idx][j];
            end
            for (int j = 0; j < SENSOR_COUNT; j++) begin
                r.sensor   = 4'(j);
                r.avg_rate = 40'(sums[j] / n);
                r.avg_dose = 32'(dsum / n);
                r.win_len  = 6'(n);
                r.win_full = full;
                r.last     = (j == SENSOR_COUNT - 1);
                due_q.push_back(r);
            end
        endfunction

        // Applies one accepted input beat to the mirrored state.
        function void note_frame(frame_t f);
            case (f.op)
                OP_HEADER: begin
                    if (f.rsel < 2) rng = f.rsel[0];
                    rate = f.rate;
                    dose = f.dose;
                    frames = 0;
                end
                OP_COUNT: begin
                    if (frames < FRAMES_PER_SET) begin
                        for (int j = 0; j < 4; j++) staging[frames*4 + j] = f.cnt[j];
                        frames++;
                        if (frames == FRAMES_PER_SET) complete_set();
                    end
                end
                OP_GAIN: begin
                    if (f.gidx < SENSOR_COUNT && f.rsel < 2)
                        gains[f.rsel*SENSOR_COUNT + f.gidx] = f.gval;
                end
                default: ;
            endcase
        endfunction

        // Compares one output beat with the oldest average still due.
        function void check_average(logic [M_TDATA_W-1:0] d, logic tl);
            average_t e;
            if (due_q.size() == 0) begin
                $error("unexpected output beat: tdata=%h", d);
                errors++;
                return;
            end
            e = due_q.pop_front();
            if (d[3:0] !== e.sensor) begin
                $error("sensor_index: expected %0d, got %0d", e.sensor, d[3:0]);
                errors++;
            end
            if (d[43:4] !== e.avg_rate) begin
                $error("corrected_average: expected %h, got %h", e.avg_rate, d[43:4]);
                errors++;
            end
            if (d[75:44] !== e.avg_dose) begin
                $error("average_dose: expected %h, got %h", e.avg_dose, d[75:44]);
                errors++;
            end
            if (d[81:76] !== e.win_len) begin
                $error("window_length: expected %0d, got %0d", e.win_len, d[81:76]);
                errors++;
            end
            if (d[82] !== e.win_full) begin
                $error("window_full: expected %0d, got %0d", e.win_full, d[82]);
                errors++;
            end
            if (tl !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, tl);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [31:0]          cfg_data = '0;

    window_average_board_t board = new();
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;
    int beats_sent     = 0;

    deadtime_corrected_window_averager i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Output side: random back-pressure, result checking and the watchdog.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_average(m_tdata, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_frame(frame_t f);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {f.rsel, f.op};
        s_tdata  <= {2'b00, f.gval, f.gidx, f.cnt[3], f.cnt[2], f.cnt[1], f.cnt[0],
                     f.dose, f.rate};
        do @(posedge aclk); while (!s_tready);
        board.note_frame(f);
        beats_sent++;
    endtask

    // One register write, then the configuration channel is left idle before return.
    task automatic write_dead_time(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_dead_time(idx, val);
        @(posedge aclk);
    endtask

    // Holds off the sender until every average has come and the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic frame_t random_frame(logic [1:0] op);
        frame_t f;
        f.op   = op;
        f.rsel = 2'($urandom_range(3));
        f.rate = 16'($urandom);
        f.dose = $urandom;
        foreach (f.cnt[j])
            f.cnt[j] = ($urandom_range(1)) ? 16'($urandom_range(255)) : 16'($urandom);
        f.gidx = 4'($urandom);
        f.gval = ($urandom_range(1)) ? 18'($urandom) : 18'($urandom_range(65536, 70000));
        return f;
    endfunction

    function automatic frame_t header_frame();
        frame_t f;
        f = random_frame(OP_HEADER);
        case ($urandom_range(2))
            0: f.rate = 16'($urandom_range(0, 2));
            1: f.rate = 16'($urandom_range(3, 11));
            default: ;
        endcase
        return f;
    endfunction

    function automatic frame_t gain_frame(logic [3:0] idx, logic [1:0] rs, logic [17:0] g);
        frame_t f;
        f = random_frame(OP_GAIN);
        f.gidx = idx;
        f.rsel = rs;
        f.gval = g;
        return f;
    endfunction

    task automatic run_phase(int n_items);
        int done;
        frame_t f;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99) < 80) begin
                // Well-formed set: optional gain loads, a header, three count frames, sometimes one extra.
                repeat ($urandom_range(2)) begin
                    send_frame(gain_frame(4'($urandom_range(11)), 2'($urandom_range(1)),
                                          18'($urandom)));
                    done++;
                end
                send_frame(header_frame());
                for (int k = 0; k < 3; k++) send_frame(random_frame(OP_COUNT));
                done += 4;
                if ($urandom_range(9) == 0) begin
                    send_frame(random_frame(OP_COUNT));
                    done++;
                end
            end else begin
                // Noise: stray beats of any kind, including out-of-range gain loads.
                f = random_frame(2'($urandom_range(3)));
                send_frame(f);
                done++;
            end
        end
    endtask

    initial begin
        frame_t f;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: gain extremes, ignored loads, counts before any header,
        // extra count frames, unused opcode and header range keep.
        write_dead_time(CFG_DT_LOW, 32'd0);
        write_dead_time(CFG_DT_HIGH, 32'hFFFF_FFFF);
        send_frame(gain_frame(4'd0, 2'd0, 18'h3FFFF));
        send_frame(gain_frame(4'd11, 2'd1, 18'h10000));
        send_frame(gain_frame(4'd12, 2'd0, 18'h3FFFF));
        send_frame(gain_frame(4'd15, 2'd1, 18'h00001));
        send_frame(gain_frame(4'd5, 2'd3, 18'h3FFFF));
        for (int k = 0; k < 3; k++) begin
            f = random_frame(OP_COUNT);
            foreach (f.cnt[j]) f.cnt[j] = (k == 0) ? 16'hFFFF : 16'h0000;
            send_frame(f);
        end
        send_frame(random_frame(OP_COUNT));
        send_frame(random_frame(OP_NONE));
        f = header_frame();
        f.rsel = 2'd1; f.rate = 16'd0; f.dose = 32'hFFFF_FFFF;
        send_frame(f);
        for (int k = 0; k < 3; k++) send_frame(random_frame(OP_COUNT));
        f = header_frame();
        f.rsel = 2'd2; f.rate = 16'hFFFF; f.dose = 32'd0;
        send_frame(f);
        for (int k = 0; k < 3; k++) send_frame(random_frame(OP_COUNT));
        drain();

        // Random phases, each with its own dead times and idling pattern.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  stall_pct = 0;
                    write_dead_time(CFG_DT_LOW, 32'($urandom_range(65535)));
                    write_dead_time(CFG_DT_HIGH, 32'($urandom_range(262143)));
                end
                1: begin
                    send_idle_pct = 50; stall_pct = 0;
                    write_dead_time(CFG_DT_LOW, 32'hFFFF_FFFF);
                    write_dead_time(CFG_DT_HIGH, 32'd0);
                end
                2: begin
                    send_idle_pct = 0;  stall_pct = 50;
                    write_dead_time(CFG_DT_LOW, $urandom);
                    write_dead_time(CFG_DT_HIGH, 32'($urandom_range(4095)));
                end
                default: begin
                    send_idle_pct = 34; stall_pct = 34;
                    write_dead_time(CFG_DT_LOW, 32'($urandom_range(1023)));
                    write_dead_time(CFG_DT_HIGH, $urandom);
                end
            endcase
            run_phase(78);
            drain();
        end

        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
